[rtl/vector_distance_accumulator_core_defines.svh]
// Assertion macros for the vector distance accumulator.
// Expects clk and arst_n in the scope of the including module.
`ifndef VECTOR_DISTANCE_ACCUMULATOR_CORE_DEFINES_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_CORE_DEFINES_SVH

// Check a property on every clock outside reset.
`define VDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define VDA_ASSERT_IMPL(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);

`endif

[rtl/vda_pkg.sv]
// Shared constants, types and codes for the vector distance accumulator.
// No dependencies.
`default_nettype none
package vda_pkg;
	localparam int MAX_LEN    = 1024;
	localparam int CNT_W      = $clog2(MAX_LEN + 2);
	localparam int VAL_W      = 16;
	localparam int MAG_W      = VAL_W + 1;
	localparam int ADD_W      = 2 * MAG_W;
	localparam int SUM_W      = 44;
	localparam int DIST_W     = 26;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] METRIC_EUCLID    = 2'd0;
	localparam logic [1:0] METRIC_MANHATTAN = 2'd1;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             over;
		logic [1:0]       metric;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

[rtl/vda_in_if.sv]
// Input channel for element pairs: valid, ready and pair payload.
// Depends on vda_pkg.
`default_nettype none
interface vda_in_if import vda_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] first_value;
	logic signed [VAL_W-1:0] second_value;
	logic                    last_pair;

	modport source (output valid, output first_value, output second_value,
		output last_pair, input ready);
	modport sink (input valid, input first_value, input second_value,
		input last_pair, output ready);
endinterface
`default_nettype wire

[rtl/vda_out_if.sv]
// Output channel for distance results: valid, ready and result payload.
// Depends on vda_pkg.
`default_nettype none
interface vda_out_if import vda_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              bad_metric;

	modport source (output valid, output distance, output bad_metric, input ready);
	modport sink (input valid, input distance, input bad_metric, output ready);
endinterface
`default_nettype wire

[rtl/vda_front.sv]
// Front end: accepts pairs, forms the per-pair term, keeps the running sum.
// Pushes one job per vector into the queue. Depends on vda_pkg, vda_in_if.
`default_nettype none
module vda_front import vda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] metric,
	vda_in_if.sink     pair_ch,
	input  q_stat_t    q_stat,
	output logic       push,
	output job_t       job
);
	logic signed [MAG_W-1:0] diff;
	logic [MAG_W-1:0]        mag;
	logic [ADD_W-1:0]        add_c;
	logic                    stall;
	logic                    accept;
	logic [SUM_W:0]          sum_wide;
	logic [SUM_W-1:0]        sum_sat;
	logic [CNT_W-1:0]        cnt_next;

	logic                    valid_s1;
	logic                    last_s1;
	logic [1:0]              metric_s1;
	logic [ADD_W-1:0]        add_s1;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;

	assign diff = $signed({pair_ch.second_value[VAL_W-1], pair_ch.second_value})
		- $signed({pair_ch.first_value[VAL_W-1], pair_ch.first_value});
	assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

	always_comb begin
		case (metric)
			METRIC_EUCLID:    add_c = mag * mag;
			METRIC_MANHATTAN: add_c = ADD_W'(mag);
			default:          add_c = '0;
		endcase
	end

	assign stall         = valid_s1 && last_s1 && q_stat.full;
	assign pair_ch.ready = !stall;
	assign accept        = pair_ch.valid && !stall;

	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(add_s1);
	assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
	assign cnt_next = (cnt_q <= CNT_W'(MAX_LEN)) ? cnt_q + CNT_W'(1) : cnt_q;

	assign push       = valid_s1 && last_s1 && !q_stat.full;
	assign job.sum    = sum_sat;
	assign job.over   = cnt_next > CNT_W'(MAX_LEN);
	assign job.metric = metric_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else if (!stall) begin
			valid_s1 <= accept;
			if (valid_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_sat;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= pair_ch.last_pair;
			metric_s1 <= metric;
			add_s1    <= add_c;
		end
	end
endmodule
`default_nettype wire

[rtl/vda_queue.sv]
// Short job queue between front and back ends.
// Depends on vda_pkg.
`default_nettype none
module vda_queue import vda_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    pop_job,
	output q_stat_t q_stat
);
	job_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_stat.full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign pop_job      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/vda_back.sv]
// Back end: takes jobs, drives results; Euclidean jobs run the iterative
// square root. Depends on vda_pkg, vda_out_if.
`default_nettype none
module vda_back import vda_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  job_t    job,
	output logic    pop,
	vda_out_if.source result_ch
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROOT = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [SUM_W-1:0]  x_q;
	logic [SUM_W-1:0]  res_q;
	logic [SUM_W-1:0]  bit_q;
	logic [STEP_W-1:0] step_q;
	logic [DIST_W-1:0] dist_q;
	logic              bad_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_bad_q;

	logic [SUM_W-1:0]  trial;
	logic              take;
	logic [SUM_W-1:0]  res_nxt;
	logic              out_free;
	logic              job_bad;

	assign trial    = res_q + bit_q;
	assign take     = x_q >= trial;
	assign res_nxt  = take ? (res_q >> 1) + bit_q : res_q >> 1;
	assign out_free = !out_valid_q || result_ch.ready;
	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign job_bad  = (job.metric != METRIC_EUCLID) && (job.metric != METRIC_MANHATTAN);

	assign result_ch.valid      = out_valid_q;
	assign result_ch.distance   = out_dist_q;
	assign result_ch.bad_metric = out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q <= '0;
						if (job_bad || job.over || job.metric == METRIC_MANHATTAN) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			x_q   <= job.sum;
			res_q <= '0;
			bit_q <= SUM_W'(1) << (SUM_W - 2);
			bad_q <= job_bad;
			if (job_bad) begin
				dist_q <= '0;
			end else if (job.over) begin
				dist_q <= DIST_MAX;
			end else if (job.sum > SUM_W'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= job.sum[DIST_W-1:0];
			end
		end
		if (state_q == ST_ROOT) begin
			if (take) begin
				x_q <= x_q - trial;
			end
			res_q <= res_nxt;
			bit_q <= bit_q >> 2;
			if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
				dist_q <= res_nxt[DIST_W-1:0];
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_dist_q <= dist_q;
			out_bad_q  <= bad_q;
		end
	end
endmodule
`default_nettype wire

[rtl/vector_distance_accumulator_core.sv]
// A final pair's result skips the square root for Manhattan, an invalid metric or an
// over-length vector; Euclidean takes the 22-step square root in the back end.
// Throughput: one pair per cycle unless a final pair waits on a full queue; the shared
// square-root unit limits Euclidean results; a 2-entry job queue absorbs short vectors.
// Reset: clears the running sum, pair count, job queue and output; metric is Euclidean.
// Top level of the vector distance accumulator; depends on vda_pkg, channel interfaces,
// vda_front, vda_queue, vda_back and the assertion macro header.
`default_nettype none
`include "vector_distance_accumulator_core_defines.svh"
module vector_distance_accumulator_core import vda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	vda_in_if.sink     pair_ch,
	vda_out_if.source  result_ch
);
	logic [1:0] metric_q;
	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       pop_job;
	q_stat_t    q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_EUCLID;
		end else if (cfg_we) begin
			metric_q <= cfg_wdata;
		end
	end

	vda_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.metric  (metric_q),
		.pair_ch (pair_ch),
		.q_stat  (q_stat),
		.push    (push),
		.job     (push_job)
	);

	vda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	vda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.job       (pop_job),
		.pop       (pop),
		.result_ch (result_ch)
	);

	`VDA_ASSERT(a_no_push_full, !(push && q_stat.full), "push into full job queue")
	`VDA_ASSERT(a_no_pop_empty, !(pop && q_stat.empty), "pop from empty job queue")
	`VDA_ASSERT_IMPL(a_bad_zero, result_ch.valid && result_ch.bad_metric, result_ch.distance == '0, "bad metric result with nonzero distance")
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for vector_distance_accumulator_core: streams element pairs,
// predicts each result for every metric code and compares every result item.
// Depends on vda_pkg, vda_in_if, vda_out_if and the RTL of the core.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import vda_pkg::*;

	localparam logic [1:0] METRIC_RESERVED_LO = 2'd2;
	localparam logic [1:0] METRIC_RESERVED_HI = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PAIRS = 950;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              bad_metric;
	} dist_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	vda_in_if  pair_ch();
	vda_out_if result_ch();

	vector_distance_accumulator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pair_ch   (pair_ch),
		.result_ch (result_ch)
	);

	logic [1:0]       metric_sel;
	logic [SUM_W-1:0] dist_sum;
	int unsigned      pairs_seen;
	dist_result_t     pending_results[$];
	int unsigned      mismatches;
	bit               in_calm;
	bit               out_calm;
	int unsigned      out_hold;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = SUM_W / 2 - 1; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if (64'(trial) * 64'(trial) <= 64'(x))
				root = trial;
		end
		return root[DIST_W-1:0];
	endfunction

	function automatic void accumulate_pair(input logic signed [VAL_W-1:0] first_elem,
		input logic signed [VAL_W-1:0] second_elem, input logic last);
		logic signed [VAL_W:0] diff;
		logic [MAG_W-1:0]      mag;
		logic [SUM_W-1:0]      add;
		logic [SUM_W:0]        total;
		dist_result_t          r;
		diff = $signed({second_elem[VAL_W-1], second_elem})
			- $signed({first_elem[VAL_W-1], first_elem});
		mag = diff[VAL_W] ? MAG_W'(-diff) : MAG_W'(diff);
		add = '0;
		if (metric_sel == METRIC_EUCLID)
			add = SUM_W'(mag) * SUM_W'(mag);
		else if (metric_sel == METRIC_MANHATTAN)
			add = SUM_W'(mag);
		total = {1'b0, dist_sum} + {1'b0, add};
		dist_sum = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
		if (pairs_seen <= MAX_LEN)
			pairs_seen++;
		if (!last)
			return;
		r.bad_metric = (metric_sel != METRIC_EUCLID) && (metric_sel != METRIC_MANHATTAN);
		if (r.bad_metric)
			r.distance = '0;
		else if (pairs_seen > MAX_LEN)
			r.distance = DIST_MAX;
		else if (metric_sel == METRIC_EUCLID)
			r.distance = floor_root(dist_sum);
		else if (dist_sum > SUM_W'(DIST_MAX))
			r.distance = DIST_MAX;
		else
			r.distance = dist_sum[DIST_W-1:0];
		pending_results.insert(pending_results.size(), r);
		dist_sum = '0;
		pairs_seen = 0;
	endfunction

	function automatic logic [VAL_W-1:0] draw_element();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return VAL_W'($urandom_range(0, 511)) - 16'd256;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic send_pair(input logic signed [VAL_W-1:0] first_elem,
		input logic signed [VAL_W-1:0] second_elem, input logic last);
		int unsigned gap;
		gap = in_calm ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			pair_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_ch.valid        = 1'b1;
		pair_ch.first_value  = first_elem;
		pair_ch.second_value = second_elem;
		pair_ch.last_pair    = last;
		do @(posedge clk); while (!pair_ch.ready);
		accumulate_pair(first_elem, second_elem, last);
	endtask

	task automatic drain_block();
		@(negedge clk);
		pair_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_metric(input logic [1:0] code);
		drain_block();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = code;
		@(negedge clk);
		cfg_we = 1'b0;
		metric_sel = code;
	endtask

	task automatic send_long_run(input int unsigned count, input logic close);
		for (int unsigned i = 0; i < count; i++)
			send_pair(i[0] ? 16'sh7FFF : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7FFF,
				close && (i == count - 1));
	endtask

	task automatic test_extremes();
		set_metric(METRIC_EUCLID);
		send_pair(16'sh8000, 16'sh7FFF, 1'b1);
		send_pair(16'sh7FFF, 16'sh8000, 1'b1);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b0);
		send_pair(16'sh7FFF, 16'sh8000, 1'b1);
		set_metric(METRIC_MANHATTAN);
		send_pair(16'sh8000, 16'sh7FFF, 1'b1);
		send_pair(16'sh0001, -16'sh0001, 1'b0);
		send_pair(16'sh7FFF, 16'sh8000, 1'b1);
		set_metric(METRIC_RESERVED_LO);
		send_pair(16'sh0064, -16'sh0064, 1'b1);
		set_metric(METRIC_RESERVED_HI);
		send_pair(16'sh8000, 16'sh7FFF, 1'b0);
		send_pair(16'sh0005, 16'sh0007, 1'b1);
	endtask

	task automatic test_metric_switch();
		set_metric(METRIC_EUCLID);
		send_pair(16'sh0000, 16'sh0003, 1'b0);
		send_pair(16'sh0000, 16'sh0004, 1'b0);
		set_metric(METRIC_MANHATTAN);
		send_pair(16'sh000A, -16'sh0006, 1'b1);
		send_pair(16'sh0001, 16'sh0002, 1'b0);
		set_metric(METRIC_RESERVED_LO);
		send_pair(16'sh8000, 16'sh7FFF, 1'b0);
		set_metric(METRIC_EUCLID);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
		send_pair(16'sh0003, 16'sh0000, 1'b0);
		set_metric(METRIC_RESERVED_HI);
		send_pair(16'sh0000, 16'sh0000, 1'b1);
	endtask

	task automatic test_length_limit();
		in_calm  = 1'b1;
		out_calm = 1'b1;
		set_metric(METRIC_EUCLID);
		send_long_run(MAX_LEN, 1'b1);
		set_metric(METRIC_MANHATTAN);
		send_long_run(MAX_LEN + 1, 1'b1);
		set_metric(METRIC_EUCLID);
		send_long_run(MAX_LEN, 1'b0);
		set_metric(METRIC_RESERVED_HI);
		send_pair(16'sh0000, 16'sh0001, 1'b1);
		in_calm  = 1'b0;
		out_calm = 1'b0;
	endtask

	task automatic test_random_vectors();
		int unsigned sent;
		int unsigned len;
		logic [1:0]  code;
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 5))
					0, 1: code = METRIC_EUCLID;
					2, 3: code = METRIC_MANHATTAN;
					4: code = METRIC_RESERVED_LO;
					default: code = METRIC_RESERVED_HI;
				endcase
				set_metric(code);
				in_calm  = ($urandom_range(0, 3) == 0);
				out_calm = ($urandom_range(0, 3) == 0);
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int unsigned i = 0; i < len; i++)
				send_pair(draw_element(), draw_element(), i == len - 1);
			sent += len;
		end
	endtask

	always @(negedge clk) begin
		if (out_hold != 0) begin
			result_ch.ready = 1'b0;
			out_hold--;
		end else begin
			result_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		dist_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			out_hold = out_calm ? 0 : $urandom_range(0, 17);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: distance %0d bad_metric %0b",
						result_ch.distance, result_ch.bad_metric);
			end else begin
				want = pending_results.pop_front();
				if (want.distance !== result_ch.distance
					|| want.bad_metric !== result_ch.bad_metric) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result item: expected distance %0d bad_metric %0b, %s %0d %s %0b",
							want.distance, want.bad_metric, "got distance",
							result_ch.distance, "bad_metric", result_ch.bad_metric);
				end
			end
		end
	end

	initial begin
		pair_ch.valid        = 1'b0;
		pair_ch.first_value  = '0;
		pair_ch.second_value = '0;
		pair_ch.last_pair    = 1'b0;
		result_ch.ready      = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = METRIC_EUCLID;
		arst_n               = 1'b0;
		metric_sel           = METRIC_EUCLID;
		dist_sum             = '0;
		pairs_seen           = 0;
		mismatches           = 0;
		in_calm              = 1'b0;
		out_calm             = 1'b0;
		out_hold             = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_metric_switch();
		test_length_limit();
		test_random_vectors();
		drain_block();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/vda_pkg.sv
rtl/vda_in_if.sv
rtl/vda_out_if.sv
rtl/vda_front.sv
rtl/vda_queue.sv
rtl/vda_back.sv
rtl/vector_distance_accumulator_core.sv
tb/tb_top.sv
